/* sv/price_window_indicators_assert.svh */
// Assertion macros shared by the price window indicator RTL.
`ifndef PRICE_WINDOW_INDICATORS_ASSERT_SVH
`define PRICE_WINDOW_INDICATORS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PWI_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PWI_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pwi_pkg.sv */
// Types and constants for the price window indicator block.
`timescale 1ns / 1ps
package pwi_pkg;

    localparam int RSI_LEN_DEF   = 14;
    localparam int TAIL_LEN_DEF  = 5;
    localparam int SLOPE_LEN_DEF = 10;

    localparam int PRICE_W = 32;
    localparam int RSI_W   = 15;
    localparam int QUO_W   = 32;
    localparam int DCNT_W  = 6;

    // RSI is 100.0 in Q7.8.
    localparam logic [RSI_W-1:0] RSI_FULL = 15'd25600;

    // Quotient bits produced per indicator by the shared divider.
    localparam logic [DCNT_W-1:0] RSI_QBITS   = 6'd15;
    localparam logic [DCNT_W-1:0] TAIL_QBITS  = 6'd32;
    localparam logic [DCNT_W-1:0] SLOPE_QBITS = 6'd31;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_LOAD   = 7'b0000100,
        ST_CHECK  = 7'b0001000,
        ST_DIVIDE = 7'b0010000,
        ST_NEXT   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_state;

    typedef enum logic [2:0] {
        OP_RSI   = 3'b001,
        OP_TAIL  = 3'b010,
        OP_SLOPE = 3'b100
    } t_op;

endpackage

/* sv/price_window_indicators.sv */
// Price window indicators: RSI, tail ratio and normalized slope over a price ring.
`timescale 1ns / 1ps
`include "price_window_indicators_assert.svh"
// Each accepted price is written into a ring of the last D prices, where D is the
// largest of RSI_LEN+1, TAIL_LEN and SLOPE_LEN (15 by default). A scan then reads
// the ring newest first, one entry per cycle, and builds the gain and loss sums,
// the tail extremes and the slope numerator and denominator with one
// multiply-accumulate step per entry. The three quotients then run one after
// another on a single radix-2 restoring divider (15, 32 and 31 steps). A result
// is ready sooner when an indicator is not valid or saturates, since the divider
// steps dominate. The input side stalls from the accepted price until its result
// has moved to the output register, so no new price is taken while an item is in
// progress; a finished item waits in the output register while the next price
// is taken.
module price_window_indicators
    import pwi_pkg::*;
#(
    parameter int RSI_LEN   = RSI_LEN_DEF,
    parameter int TAIL_LEN  = TAIL_LEN_DEF,
    parameter int SLOPE_LEN = SLOPE_LEN_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [PRICE_W-1:0]        i_price,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [RSI_W-1:0]          o_rsi,
    output logic                      o_rsi_valid,
    output logic [QUO_W-1:0]          o_tail,
    output logic                      o_tail_valid,
    output logic signed [QUO_W-1:0]   o_slope,
    output logic                      o_slope_valid
);

    localparam int N      = SLOPE_LEN;
    localparam int D0     = (RSI_LEN + 1 > TAIL_LEN) ? RSI_LEN + 1 : TAIL_LEN;
    localparam int D      = (D0 > N) ? D0 : N;
    localparam int PW     = $clog2(D);
    localparam int SW     = $clog2(D + 1);
    localparam int GW     = PRICE_W + $clog2(RSI_LEN);
    localparam int RXW    = GW + 15;
    localparam int SX     = N * (N - 1) / 2;
    localparam int SXX    = (N - 1) * N * (2 * N - 1) / 6;
    localparam int DEN_X  = N * SXX - SX * SX;
    localparam int DXW    = $clog2(DEN_X + 1);
    localparam int COEF0  = N * SX;
    localparam int CW     = $clog2(COEF0 + N * N + 1) + 1;
    localparam int AW0    = PRICE_W + 1 + $clog2(N * COEF0 + 1);
    localparam int AW     = (AW0 > CW + PRICE_W + 1) ? AW0 : CW + PRICE_W + 1;
    localparam int MW     = AW - 1;
    localparam int BW     = PRICE_W + $clog2(N * DEN_X + 1);
    localparam int DW0    = (GW > PRICE_W) ? GW : PRICE_W;
    localparam int DW     = (DW0 > BW) ? DW0 : BW;
    localparam int HW     = (DW > MW - 15) ? DW : MW - 15;

    localparam logic [DXW-1:0]       DEN_X_C    = DXW'(DEN_X);
    localparam logic signed [CW-1:0] COEF0_C    = CW'(COEF0);
    localparam logic signed [CW-1:0] COEF_STEP  = CW'(N * N);

    // Price ring.
    logic [PRICE_W-1:0] r_mem [D];
    logic [PRICE_W-1:0] r_rd_data;

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [PW-1:0]         r_wr_pos, n_wr_pos;
    logic [PW-1:0]         r_rd_ptr, n_rd_ptr;
    logic [SW-1:0]         r_seen, n_seen;
    logic [SW-1:0]         r_cnt, n_cnt;
    logic [PRICE_W-1:0]    r_price, n_price;
    logic [PRICE_W-1:0]    r_prev, n_prev;
    logic [PRICE_W-1:0]    r_max, n_max;
    logic [PRICE_W-1:0]    r_min, n_min;
    logic [GW-1:0]         r_gain, n_gain;
    logic [GW-1:0]         r_loss, n_loss;
    logic signed [CW-1:0]  r_coef, n_coef;
    logic signed [AW-1:0]  r_acc_a, n_acc_a;
    logic [BW-1:0]         r_acc_b, n_acc_b;
    logic [HW-1:0]         r_num, n_num;
    logic [DW-1:0]         r_den, n_den;
    logic [QUO_W-1:0]      r_lo, n_lo;
    logic [QUO_W-1:0]      r_quo, n_quo;
    logic [DCNT_W-1:0]     r_dcnt, n_dcnt;
    logic                  r_neg, n_neg;
    logic [RSI_W-1:0]      r_rsi, n_rsi;
    logic                  r_rsi_ok, n_rsi_ok;
    logic [QUO_W-1:0]      r_tail, n_tail;
    logic                  r_tail_ok, n_tail_ok;
    logic [QUO_W-1:0]      r_slope, n_slope;
    logic                  r_slope_ok, n_slope_ok;

    logic                  r_out_valid;
    logic [RSI_W-1:0]      r_out_rsi;
    logic                  r_out_rsi_ok;
    logic [QUO_W-1:0]      r_out_tail;
    logic                  r_out_tail_ok;
    logic [QUO_W-1:0]      r_out_slope;
    logic                  r_out_slope_ok;

    logic                  in_acc;
    logic                  out_load;
    logic signed [CW+PRICE_W:0]   prod_a;
    logic [DXW+PRICE_W-1:0]       prod_b;
    logic [RXW-1:0]        rsi_x;
    logic [GW-1:0]         rsi_den;
    logic [PRICE_W-1:0]    tail_up, tail_dn, tail_d;
    logic [AW-1:0]         acc_a_u, a_abs;
    logic [DW:0]           trial, diff;
    logic                  take;
    logic [QUO_W-1:0]      q_nx;

    assign in_acc   = i_valid && !o_stall;
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || !i_stall);
    assign o_stall  = (r_state != ST_IDLE);

    // Scan datapath.
    assign prod_a = r_coef * $signed({1'b0, r_rd_data});
    assign prod_b = r_rd_data * DEN_X_C;

    // Divider setup datapath; 25600 = 2^14 + 2^13 + 2^10.
    assign rsi_x   = RXW'({r_gain, 14'b0}) + RXW'({r_gain, 13'b0}) + RXW'({r_gain, 10'b0});
    assign rsi_den = r_gain + r_loss;
    assign tail_up = r_max - r_price;
    assign tail_dn = r_price - r_min;
    assign tail_d  = (tail_up > tail_dn) ? tail_up : tail_dn;
    assign acc_a_u = r_acc_a;
    assign a_abs   = acc_a_u[AW-1] ? (~acc_a_u + 1'b1) : acc_a_u;

    // One restoring division step.
    assign trial = {r_num[DW-1:0], r_lo[QUO_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign take  = !diff[DW];
    assign q_nx  = {r_quo[QUO_W-2:0], take};

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_wr_pos   = r_wr_pos;
        n_rd_ptr   = r_rd_ptr;
        n_seen     = r_seen;
        n_cnt      = r_cnt;
        n_price    = r_price;
        n_prev     = r_prev;
        n_max      = r_max;
        n_min      = r_min;
        n_gain     = r_gain;
        n_loss     = r_loss;
        n_coef     = r_coef;
        n_acc_a    = r_acc_a;
        n_acc_b    = r_acc_b;
        n_num      = r_num;
        n_den      = r_den;
        n_lo       = r_lo;
        n_quo      = r_quo;
        n_dcnt     = r_dcnt;
        n_neg      = r_neg;
        n_rsi      = r_rsi;
        n_rsi_ok   = r_rsi_ok;
        n_tail     = r_tail;
        n_tail_ok  = r_tail_ok;
        n_slope    = r_slope;
        n_slope_ok = r_slope_ok;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_price  = i_price;
                    n_max    = i_price;
                    n_min    = i_price;
                    n_rd_ptr = r_wr_pos;
                    n_wr_pos = (r_wr_pos == PW'(D - 1)) ? '0 : r_wr_pos + 1'b1;
                    if (r_seen != SW'(D)) begin
                        n_seen = r_seen + 1'b1;
                    end
                    n_cnt    = '0;
                    n_gain   = '0;
                    n_loss   = '0;
                    n_coef   = COEF0_C;
                    n_acc_a  = '0;
                    n_acc_b  = '0;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // The read issued at count c returns the entry c places back from
                // the newest one at count c+1.
                if (r_cnt != SW'(D)) begin
                    n_rd_ptr = (r_rd_ptr == '0) ? PW'(D - 1) : r_rd_ptr - 1'b1;
                    n_cnt    = r_cnt + 1'b1;
                end else begin
                    n_op    = OP_RSI;
                    n_state = ST_LOAD;
                end
                if (r_cnt != '0) begin
                    n_prev = r_rd_data;
                    if (r_cnt >= SW'(2) && r_cnt <= SW'(RSI_LEN + 1)) begin
                        if (r_prev > r_rd_data) begin
                            n_gain = r_gain + GW'(r_prev - r_rd_data);
                        end else begin
                            n_loss = r_loss + GW'(r_rd_data - r_prev);
                        end
                    end
                    if (r_cnt <= SW'(TAIL_LEN)) begin
                        if (r_rd_data > r_max) begin
                            n_max = r_rd_data;
                        end
                        if (r_rd_data < r_min) begin
                            n_min = r_rd_data;
                        end
                    end
                    if (r_cnt <= SW'(N)) begin
                        n_acc_a = r_acc_a + AW'(prod_a);
                        n_acc_b = r_acc_b + BW'(prod_b);
                        n_coef  = r_coef - COEF_STEP;
                    end
                end
            end
            ST_LOAD: begin
                n_quo   = '0;
                n_state = ST_NEXT;
                unique case (r_op)
                    OP_RSI: begin
                        n_rsi    = '0;
                        n_rsi_ok = (r_seen >= SW'(RSI_LEN + 1)) && (rsi_den != '0);
                        n_num    = HW'(rsi_x[RXW-1:15]);
                        n_den    = DW'(rsi_den);
                        n_lo     = {rsi_x[14:0], 17'b0};
                        n_dcnt   = RSI_QBITS;
                        if (n_rsi_ok) begin
                            n_state = ST_CHECK;
                        end
                    end
                    OP_TAIL: begin
                        n_tail    = '0;
                        n_tail_ok = (r_seen >= SW'(TAIL_LEN)) && (r_price != '0);
                        n_num     = HW'(tail_d[31:16]);
                        n_den     = DW'(r_price);
                        n_lo      = {tail_d[15:0], 16'b0};
                        n_dcnt    = TAIL_QBITS;
                        if (n_tail_ok) begin
                            n_state = ST_CHECK;
                        end
                    end
                    OP_SLOPE: begin
                        n_slope    = '0;
                        n_slope_ok = (r_seen >= SW'(N)) && (r_acc_b != '0);
                        n_neg      = r_acc_a[AW-1];
                        n_num      = HW'(a_abs[MW-1:15]);
                        n_den      = DW'(r_acc_b);
                        n_lo       = {a_abs[14:0], 17'b0};
                        n_dcnt     = SLOPE_QBITS;
                        if (n_slope_ok) begin
                            n_state = ST_CHECK;
                        end
                    end
                    default: begin
                        n_state = ST_NEXT;
                    end
                endcase
            end
            ST_CHECK: begin
                // The quotient overflows its field when the high part of the
                // numerator already reaches the divisor.
                if (r_num >= HW'(r_den)) begin
                    unique case (r_op)
                        OP_RSI:   n_rsi   = '1;
                        OP_TAIL:  n_tail  = '1;
                        OP_SLOPE: n_slope = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                        default:  n_rsi   = r_rsi;
                    endcase
                    n_state = ST_NEXT;
                end else begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                n_num  = HW'(take ? diff[DW-1:0] : trial[DW-1:0]);
                n_lo   = {r_lo[QUO_W-2:0], 1'b0};
                n_quo  = q_nx;
                n_dcnt = r_dcnt - 1'b1;
                if (r_dcnt == DCNT_W'(1)) begin
                    unique case (r_op)
                        OP_RSI:   n_rsi   = q_nx[RSI_W-1:0];
                        OP_TAIL:  n_tail  = q_nx;
                        OP_SLOPE: n_slope = r_neg ? (32'd0 - q_nx) : q_nx;
                        default:  n_rsi   = r_rsi;
                    endcase
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                unique case (r_op)
                    OP_RSI: begin
                        n_op    = OP_TAIL;
                        n_state = ST_LOAD;
                    end
                    OP_TAIL: begin
                        n_op    = OP_SLOPE;
                        n_state = ST_LOAD;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem[r_wr_pos] <= i_price;
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_RSI;
            r_wr_pos    <= '0;
            r_seen      <= '0;
            r_cnt       <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_wr_pos <= n_wr_pos;
            r_seen   <= n_seen;
            r_cnt    <= n_cnt;
            r_dcnt   <= n_dcnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr   <= n_rd_ptr;
        r_price    <= n_price;
        r_prev     <= n_prev;
        r_max      <= n_max;
        r_min      <= n_min;
        r_gain     <= n_gain;
        r_loss     <= n_loss;
        r_coef     <= n_coef;
        r_acc_a    <= n_acc_a;
        r_acc_b    <= n_acc_b;
        r_num      <= n_num;
        r_den      <= n_den;
        r_lo       <= n_lo;
        r_quo      <= n_quo;
        r_neg      <= n_neg;
        r_rsi      <= n_rsi;
        r_rsi_ok   <= n_rsi_ok;
        r_tail     <= n_tail;
        r_tail_ok  <= n_tail_ok;
        r_slope    <= n_slope;
        r_slope_ok <= n_slope_ok;
        if (out_load) begin
            r_out_rsi      <= r_rsi;
            r_out_rsi_ok   <= r_rsi_ok;
            r_out_tail     <= r_tail;
            r_out_tail_ok  <= r_tail_ok;
            r_out_slope    <= r_slope;
            r_out_slope_ok <= r_slope_ok;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_rsi         = r_out_rsi;
    assign o_rsi_valid   = r_out_rsi_ok;
    assign o_tail        = r_out_tail;
    assign o_tail_valid  = r_out_tail_ok;
    assign o_slope       = r_out_slope;
    assign o_slope_valid = r_out_slope_ok;

    `PWI_ASSERT_SAME(a_rsi_range, i_clk, i_rst_n, o_valid && o_rsi_valid, o_rsi <= RSI_FULL, "rsi above full scale")
    `PWI_ASSERT_SAME(a_tail_flag, i_clk, i_rst_n, o_valid && !o_tail_valid, o_tail == '0, "tail nonzero while its flag is low")
    `PWI_ASSERT_NEXT(a_scan_start, i_clk, i_rst_n, i_valid && !o_stall, r_state == ST_SCAN && r_cnt == '0, "scan did not start after an item")
    `PWI_ASSERT_SAME(a_rem_bound, i_clk, i_rst_n, r_state == ST_DIVIDE, r_num < HW'(r_den), "divider remainder not below divisor")

endmodule
